/* rtl/orctsd_pkg.sv */
// Package for the ORC timestamp decode and filter block.
// Holds the pipeline payload types, register codes and constant tables.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package orctsd_pkg;

   localparam logic [29:0] NS_MAX = 30'd999999999;

   // Precision codes; any other code keeps full nanoseconds.
   localparam logic [1:0] PREC_MS = 2'd0;
   localparam logic [1:0] PREC_US = 2'd1;
   localparam logic [1:0] PREC_NS = 2'd2;

   // Filter codes.
   localparam logic [1:0] FILT_ALL     = 2'd0;
   localparam logic [1:0] FILT_NULLS   = 2'd1;
   localparam logic [1:0] FILT_NONNULL = 2'd2;
   localparam logic [1:0] FILT_RANGE   = 2'd3;

   // Register indexes.
   localparam logic [2:0] CSR_PRECISION  = 3'd0;
   localparam logic [2:0] CSR_FILTER     = 3'd1;
   localparam logic [2:0] CSR_NULL_PASS  = 3'd2;
   localparam logic [2:0] CSR_LOW_SECS   = 3'd3;
   localparam logic [2:0] CSR_LOW_NANOS  = 3'd4;
   localparam logic [2:0] CSR_HIGH_SECS  = 3'd5;
   localparam logic [2:0] CSR_HIGH_NANOS = 3'd6;
   localparam logic [2:0] CSR_EPOCH      = 3'd7;

   // Reciprocals for exact division of values below 2^30:
   // x / 10^6 = (x * MAGIC_MS) >> 50 and x / 10^3 = (x * MAGIC_US) >> 40.
   localparam logic [30:0] MAGIC_MS = 31'd1125899907;
   localparam logic [30:0] MAGIC_US = 31'd1099511628;
   localparam logic [19:0] UNIT_MS  = 20'd1000000;
   localparam logic [19:0] UNIT_US  = 20'd1000;

   typedef struct packed {
      logic [1:0]  precision_mode;
      logic [1:0]  filter_mode;
      logic        range_null_pass;
      logic [63:0] range_low_seconds;
      logic [29:0] range_low_nanos;
      logic [63:0] range_high_seconds;
      logic [29:0] range_high_nanos;
      logic [32:0] secs_offset;
   } cfg_type;

   // Registered request as it arrives.
   typedef struct packed {
      logic [30:0] row;
      logic [63:0] sec_raw;
      logic [29:0] mant;
      logic [2:0]  zeros;
      logic        is_null;
      logic        bend;
   } in_stage_type;

   // After nanosecond expansion and the offset addition.
   typedef struct packed {
      logic [30:0] row;
      logic [63:0] secs_sum;
      logic [29:0] nanos;
      logic        is_null;
      logic        bend;
   } dec_stage_type;

   // After the seconds adjustment and the reciprocal division.
   typedef struct packed {
      logic [30:0] row;
      logic [63:0] secs;
      logic [29:0] nanos;
      logic [19:0] quot;
      logic        is_null;
      logic        bend;
   } div_stage_type;

   // Final timestamp, zeroed for null rows.
   typedef struct packed {
      logic [30:0] row;
      logic [63:0] secs;
      logic [29:0] nanos;
      logic        is_null;
      logic        bend;
   } ts_stage_type;

   typedef struct packed {
      logic [30:0] row;
      logic        selected;
      logic        is_null;
      logic [63:0] secs;
      logic [29:0] nanos;
      logic        bend;
   } rsp_type;

   // Scale applied to the mantissa for a given trailing-zero count.
   function automatic logic [26:0] pow10_scale(input logic [2:0] zeros);
      logic [26:0] scale;
      unique case (zeros)
         3'd0: scale = 27'd1;
         3'd1: scale = 27'd100;
         3'd2: scale = 27'd1000;
         3'd3: scale = 27'd10000;
         3'd4: scale = 27'd100000;
         3'd5: scale = 27'd1000000;
         3'd6: scale = 27'd10000000;
         default: scale = 27'd100000000;
      endcase
      return scale;
   endfunction

   // Largest mantissa whose scaled value stays within NS_MAX.
   function automatic logic [29:0] sat_limit(input logic [2:0] zeros);
      logic [29:0] limit;
      unique case (zeros)
         3'd0: limit = NS_MAX;
         3'd1: limit = 30'd9999999;
         3'd2: limit = 30'd999999;
         3'd3: limit = 30'd99999;
         3'd4: limit = 30'd9999;
         3'd5: limit = 30'd999;
         3'd6: limit = 30'd99;
         default: limit = 30'd9;
      endcase
      return limit;
   endfunction

endpackage

`default_nettype wire

/* rtl/orctsd_decode.sv */
// First stage logic: nanosecond expansion with saturation, offset addition.
// Depends on orctsd_pkg.
`default_nettype none

module orctsd_decode
   import orctsd_pkg::*;
(
   input  wire in_stage_type  stage_i,
   input  wire [32:0]         secs_offset,
   output dec_stage_type      stage_o
);

   logic        sat;
   logic [56:0] prod;

   // Checking the mantissa against a per-count limit keeps the product
   // itself within 30 bits whenever it is used.
   assign sat  = stage_i.mant > sat_limit(stage_i.zeros);
   assign prod = {27'd0, stage_i.mant} * {30'd0, pow10_scale(stage_i.zeros)};

   always_comb begin
      stage_o.row      = stage_i.row;
      stage_o.secs_sum = stage_i.sec_raw + {{31{secs_offset[32]}}, secs_offset};
      stage_o.nanos    = sat ? NS_MAX : prod[29:0];
      stage_o.is_null  = stage_i.is_null;
      stage_o.bend     = stage_i.bend;
   end

endmodule

`default_nettype wire

/* rtl/orctsd_divide.sv */
// Second stage logic: negative seconds adjustment and division of the
// nanoseconds by 10^6 or 10^3 through a reciprocal multiply.
// Depends on orctsd_pkg.
`default_nettype none

module orctsd_divide
   import orctsd_pkg::*;
(
   input  wire dec_stage_type stage_i,
   input  wire [1:0]          precision_mode,
   output div_stage_type      stage_o
);

   logic [30:0] magic;
   logic [60:0] prod;
   logic        borrow;

   assign magic  = (precision_mode == PREC_MS) ? MAGIC_MS : MAGIC_US;
   assign prod   = {31'd0, stage_i.nanos} * {30'd0, magic};
   assign borrow = stage_i.secs_sum[63] && (stage_i.nanos != 30'd0);

   always_comb begin
      stage_o.row     = stage_i.row;
      stage_o.secs    = stage_i.secs_sum - {63'd0, borrow};
      stage_o.nanos   = stage_i.nanos;
      stage_o.quot    = (precision_mode == PREC_MS) ? {10'd0, prod[59:50]} : prod[59:40];
      stage_o.is_null = stage_i.is_null;
      stage_o.bend    = stage_i.bend;
   end

endmodule

`default_nettype wire

/* rtl/orctsd_scale.sv */
// Third stage logic: rebuilds the truncated nanoseconds from the quotient
// and clears the timestamp of null rows. Depends on orctsd_pkg.
`default_nettype none

module orctsd_scale
   import orctsd_pkg::*;
(
   input  wire div_stage_type stage_i,
   input  wire [1:0]          precision_mode,
   output ts_stage_type       stage_o
);

   logic [39:0] prod_ms;
   logic [39:0] prod_us;
   logic [29:0] nanos;

   assign prod_ms = {20'd0, stage_i.quot} * {20'd0, UNIT_MS};
   assign prod_us = {20'd0, stage_i.quot} * {20'd0, UNIT_US};

   always_comb begin
      unique case (precision_mode)
         PREC_MS: nanos = prod_ms[29:0];
         PREC_US: nanos = prod_us[29:0];
         default: nanos = stage_i.nanos;
      endcase
   end

   always_comb begin
      stage_o.row     = stage_i.row;
      stage_o.secs    = stage_i.is_null ? 64'd0 : stage_i.secs;
      stage_o.nanos   = stage_i.is_null ? 30'd0 : nanos;
      stage_o.is_null = stage_i.is_null;
      stage_o.bend    = stage_i.bend;
   end

endmodule

`default_nettype wire

/* rtl/orctsd_filter.sv */
// Last stage logic: row selection by filter mode and inclusive range.
// Depends on orctsd_pkg.
`default_nettype none

module orctsd_filter
   import orctsd_pkg::*;
(
   input  wire ts_stage_type stage_i,
   input  wire cfg_type      cfg,
   output rsp_type           stage_o
);

   logic low_ok;
   logic high_ok;
   logic sel;

   // Lexicographic comparison of (seconds, nanoseconds) pairs.
   always_comb begin
      if (cfg.range_low_seconds != stage_i.secs) begin
         low_ok = $signed(cfg.range_low_seconds) < $signed(stage_i.secs);
      end else begin
         low_ok = cfg.range_low_nanos <= stage_i.nanos;
      end
      if (stage_i.secs != cfg.range_high_seconds) begin
         high_ok = $signed(stage_i.secs) < $signed(cfg.range_high_seconds);
      end else begin
         high_ok = stage_i.nanos <= cfg.range_high_nanos;
      end
   end

   always_comb begin
      unique case (cfg.filter_mode)
         FILT_ALL:     sel = 1'b1;
         FILT_NULLS:   sel = stage_i.is_null;
         FILT_NONNULL: sel = !stage_i.is_null;
         FILT_RANGE:   sel = stage_i.is_null ? cfg.range_null_pass : (low_ok && high_ok);
         default:      sel = 1'b1;
      endcase
   end

   always_comb begin
      stage_o.row      = stage_i.row;
      stage_o.selected = sel;
      stage_o.is_null  = stage_i.is_null;
      stage_o.secs     = stage_i.secs;
      stage_o.nanos    = stage_i.nanos;
      stage_o.bend     = stage_i.bend;
   end

endmodule

`default_nettype wire

/* rtl/orc_timestamp_decode_filter.sv */
// Top level of the ORC timestamp decode and row filter block.
// Depends on orctsd_pkg, orctsd_decode, orctsd_divide, orctsd_scale and orctsd_filter.
//
//   Channel   Direction  Handshake               Contents
//   req_*     in         req_tvalid/req_tready   one row: number, seconds, nanos, flags
//   rsp_*     out        rsp_tvalid/rsp_tready   one decoded row with its verdict
//   csr_*     in         csr_wen                 register write, no read-back
//
// One request is accepted per cycle while req_tready is high, and each gives
// exactly one response. The input register is followed by the three
// multipliers (mantissa scaling, reciprocal division, quotient rescaling),
// each followed by a register, then by the filter and the output register.
// Reset is synchronous and clears the valid bits and the configuration
// registers. A stall of rsp_tready holds the output; the stages behind it
// keep filling empty slots, so req_tready only falls once all five stages
// hold a row.
`default_nettype none

module orc_timestamp_decode_filter
   import orctsd_pkg::*;
(
   input  wire          clock,
   input  wire          reset,

   input  wire          req_tvalid,
   output logic         req_tready,
   // [30:0] row_number, [94:31] seconds_raw, [127:95] nanos_raw
   input  wire [127:0]  req_tdata,
   // [0] value_is_null
   input  wire          req_tuser,
   input  wire          req_tlast,

   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [30:0] row_number_out, [94:31] epoch_seconds, [124:95] nanoseconds,
   // [127:125] zero
   output logic [127:0] rsp_tdata,
   // [0] selected, [1] null_out
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,

   input  wire          csr_wen,
   input  wire [2:0]    csr_index,
   input  wire [63:0]   csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_PRECISION:  cfg_in.precision_mode     = csr_wdata[1:0];
            CSR_FILTER:     cfg_in.filter_mode        = csr_wdata[1:0];
            CSR_NULL_PASS:  cfg_in.range_null_pass    = csr_wdata[0];
            CSR_LOW_SECS:   cfg_in.range_low_seconds  = csr_wdata;
            CSR_LOW_NANOS:  cfg_in.range_low_nanos    = csr_wdata[29:0];
            CSR_HIGH_SECS:  cfg_in.range_high_seconds = csr_wdata;
            CSR_HIGH_NANOS: cfg_in.range_high_nanos   = csr_wdata[29:0];
            CSR_EPOCH:      cfg_in.secs_offset        = csr_wdata[32:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.precision_mode     <= PREC_NS;
         cfg_ff.filter_mode        <= FILT_ALL;
         cfg_ff.range_null_pass    <= 1'b0;
         cfg_ff.range_low_seconds  <= 64'h8000_0000_0000_0000;
         cfg_ff.range_low_nanos    <= 30'd0;
         cfg_ff.range_high_seconds <= 64'h7FFF_FFFF_FFFF_FFFF;
         cfg_ff.range_high_nanos   <= NS_MAX;
         cfg_ff.secs_offset        <= 33'd1420070400;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline: stage 0 input register, 1 decoded, 2 divided, 3 final
   // timestamp, 4 output register. A stage loads when it is empty or when
   // the stage after it moves on, so bubbles are squeezed out.
   logic [4:0]    valid_ff;
   logic [4:0]    valid_in;
   logic [4:0]    advance;

   in_stage_type  in_ff;
   in_stage_type  in_in;
   dec_stage_type dec_ff;
   dec_stage_type dec_in;
   div_stage_type div_ff;
   div_stage_type div_in;
   ts_stage_type  ts_ff;
   ts_stage_type  ts_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   always_comb begin
      advance[4] = !valid_ff[4] || rsp_tready;
      advance[3] = !valid_ff[3] || advance[4];
      advance[2] = !valid_ff[2] || advance[3];
      advance[1] = !valid_ff[1] || advance[2];
      advance[0] = !valid_ff[0] || advance[1];
   end

   assign req_tready = advance[0];

   always_comb begin
      valid_in = valid_ff;
      if (advance[0]) valid_in[0] = req_tvalid;
      if (advance[1]) valid_in[1] = valid_ff[0];
      if (advance[2]) valid_in[2] = valid_ff[1];
      if (advance[3]) valid_in[3] = valid_ff[2];
      if (advance[4]) valid_in[4] = valid_ff[3];
   end

   always_comb begin
      in_in.row     = req_tdata[30:0];
      in_in.sec_raw = req_tdata[94:31];
      in_in.zeros   = req_tdata[97:95];
      in_in.mant    = req_tdata[127:98];
      in_in.is_null = req_tuser;
      in_in.bend    = req_tlast;
   end

   orctsd_decode u_decode (
      .stage_i     (in_ff),
      .secs_offset (cfg_ff.secs_offset),
      .stage_o     (dec_in)
   );

   orctsd_divide u_divide (
      .stage_i        (dec_ff),
      .precision_mode (cfg_ff.precision_mode),
      .stage_o        (div_in)
   );

   orctsd_scale u_scale (
      .stage_i        (div_ff),
      .precision_mode (cfg_ff.precision_mode),
      .stage_o        (ts_in)
   );

   orctsd_filter u_filter (
      .stage_i (ts_ff),
      .cfg     (cfg_ff),
      .stage_o (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 5'd0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (advance[0]) in_ff  <= in_in;
      if (advance[1]) dec_ff <= dec_in;
      if (advance[2]) div_ff <= div_in;
      if (advance[3]) ts_ff  <= ts_in;
      if (advance[4]) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = valid_ff[4];
   assign rsp_tdata  = {3'd0, rsp_ff.nanos, rsp_ff.secs, rsp_ff.row};
   assign rsp_tuser  = {rsp_ff.is_null, rsp_ff.selected};
   assign rsp_tlast  = rsp_ff.bend;

   // A null row always leaves with a cleared timestamp.
   a_null_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.is_null |-> rsp_ff.secs == 64'd0 && rsp_ff.nanos == 30'd0)
      else $error("null row carries a nonzero timestamp");

   // Saturation and truncation never push nanoseconds past the maximum.
   a_nanos_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> ts_ff.nanos <= NS_MAX)
      else $error("nanoseconds above the maximum");

   // Any empty stage means a new request can be taken.
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> req_tready)
      else $error("request refused while the pipeline has room");

   // A row held at the output by a stall is not overtaken.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && !rsp_tready |=> valid_ff[4] && $stable(rsp_ff))
      else $error("stalled response changed");

endmodule

`default_nettype wire

/* tb/orc_timestamp_decode_filter_tb.sv */
// Self-checking testbench for orc_timestamp_decode_filter: streams rows through the block
// under a series of register settings and compares every decoded row with a local predictor.
// Depends on orctsd_pkg and the block's RTL only.
`timescale 1ns / 1ps

import orctsd_pkg::*;

localparam logic [1:0] PREC_CODE3 = 2'd3;

function automatic logic [63:0] ten_pow(int n);
   logic [63:0] v;
   v = 64'd1;
   for (int k = 0; k < n; k++)
      v = v * 64'd10;
   return v;
endfunction

// Mostly well-formed nanosecond encodings, with some exact and just-over limits.
function automatic logic [32:0] random_nanos();
   logic [2:0]  z;
   logic [63:0] limit;
   logic [63:0] m;
   z = 3'($urandom_range(0, 7));
   limit = (z == 3'd0) ? 64'(NS_MAX) : 64'(NS_MAX) / ten_pow(int'(z) + 1);
   case ($urandom_range(0, 7))
      0: m = 64'd0;
      1: m = limit;
      2: m = limit + 64'd1;
      default: m = 64'($urandom_range(0, 32'(limit)));
   endcase
   return {m[29:0], z};
endfunction

class decode_scoreboard;
   cfg_type     regs;
   rsp_type     pending_rows[$];
   int unsigned failures;

   function new();
      regs.precision_mode     = PREC_NS;
      regs.filter_mode        = FILT_ALL;
      regs.range_null_pass    = 1'b0;
      regs.range_low_seconds  = 64'h8000_0000_0000_0000;
      regs.range_low_nanos    = 30'd0;
      regs.range_high_seconds = 64'h7FFF_FFFF_FFFF_FFFF;
      regs.range_high_nanos   = NS_MAX;
      regs.secs_offset        = 33'd1420070400;
      failures = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
         CSR_PRECISION:  regs.precision_mode     = v[1:0];
         CSR_FILTER:     regs.filter_mode        = v[1:0];
         CSR_NULL_PASS:  regs.range_null_pass    = v[0];
         CSR_LOW_SECS:   regs.range_low_seconds  = v;
         CSR_LOW_NANOS:  regs.range_low_nanos    = v[29:0];
         CSR_HIGH_SECS:  regs.range_high_seconds = v;
         CSR_HIGH_NANOS: regs.range_high_nanos   = v[29:0];
         default:        regs.secs_offset        = v[32:0];
      endcase
   endfunction

   // Inclusive lexicographic (seconds, nanoseconds) ordering, seconds signed.
   function bit not_later(logic [63:0] s1, logic [29:0] n1, logic [63:0] s2, logic [29:0] n2);
      if (s1 != s2)
         return $signed(s1) < $signed(s2);
      return n1 <= n2;
   endfunction

   function rsp_type decode_row(logic [30:0] row, logic [63:0] sec_raw, logic [32:0] nraw,
                                logic nul, logic bend);
      rsp_type     r;
      logic [63:0] off;
      logic [63:0] nanos;
      logic [63:0] secs;
      logic [2:0]  z;
      z = nraw[2:0];
      nanos = {34'd0, nraw[32:3]};
      if (z != 3'd0)
         nanos = nanos * ten_pow(int'(z) + 1);
      if (nanos > 64'(NS_MAX))
         nanos = 64'(NS_MAX);
      off = {{31{regs.secs_offset[32]}}, regs.secs_offset};
      secs = sec_raw + off;
      if (secs[63] && nanos != 64'd0)
         secs = secs - 64'd1;
      if (regs.precision_mode == PREC_MS)
         nanos = nanos / 64'(UNIT_MS) * 64'(UNIT_MS);
      else if (regs.precision_mode == PREC_US)
         nanos = nanos / 64'(UNIT_US) * 64'(UNIT_US);
      if (nul) begin
         secs  = 64'd0;
         nanos = 64'd0;
      end
      r.row     = row;
      r.is_null = nul;
      r.secs    = secs;
      r.nanos   = nanos[29:0];
      r.bend    = bend;
      case (regs.filter_mode)
         FILT_NULLS:   r.selected = nul;
         FILT_NONNULL: r.selected = !nul;
         FILT_RANGE: begin
            if (nul)
               r.selected = regs.range_null_pass;
            else
               r.selected = not_later(regs.range_low_seconds, regs.range_low_nanos,
                                      secs, nanos[29:0]) &&
                            not_later(secs, nanos[29:0],
                                      regs.range_high_seconds, regs.range_high_nanos);
         end
         default:      r.selected = 1'b1;
      endcase
      return r;
   endfunction

   function void note_request(logic [30:0] row, logic [63:0] sec_raw, logic [32:0] nraw,
                              logic nul, logic bend);
      pending_rows.push_back(decode_row(row, sec_raw, nraw, nul, bend));
   endfunction

   function void check_response(logic [127:0] d, logic [1:0] u, logic l);
      rsp_type e;
      if (pending_rows.size() == 0) begin
         $error("response for row %0d with no request outstanding", d[30:0]);
         failures++;
         return;
      end
      e = pending_rows.pop_front();
      if (d[30:0] !== e.row) begin
         $error("row_number_out: expected %0d, got %0d", e.row, d[30:0]);
         failures++;
      end
      if (u[0] !== e.selected) begin
         $error("selected: expected %0b, got %0b", e.selected, u[0]);
         failures++;
      end
      if (u[1] !== e.is_null) begin
         $error("null_out: expected %0b, got %0b", e.is_null, u[1]);
         failures++;
      end
      if (d[94:31] !== e.secs) begin
         $error("epoch_seconds: expected %0d, got %0d", $signed(e.secs), $signed(d[94:31]));
         failures++;
      end
      if (d[124:95] !== e.nanos) begin
         $error("nanoseconds: expected %0d, got %0d", e.nanos, d[124:95]);
         failures++;
      end
      if (l !== e.bend) begin
         $error("batch_end_out: expected %0b, got %0b", e.bend, l);
         failures++;
      end
   endfunction
endclass

module orc_timestamp_decode_filter_tb;

   localparam int NUM_PHASES     = 10;
   localparam int ROWS_PER_PHASE = 140;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [30:0] row_number, [94:31] seconds_raw, [127:95] nanos_raw
   logic [127:0] req_tdata = '0;
   // [0] value_is_null
   logic         req_tuser = 1'b0;
   logic         req_tlast = 1'b0;

   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [30:0] row_number_out, [94:31] epoch_seconds, [124:95] nanoseconds, [127:125] zero
   logic [127:0] rsp_tdata;
   // [0] selected, [1] null_out
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   logic         csr_wen = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   // Enables random idle bursts on both channels; cleared for stretches without idling
   // and for the final phase of the run.
   logic         idle_on = 1'b1;
   int unsigned  rsp_hold = 0;

   decode_scoreboard sb;

   orc_timestamp_decode_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Response side. Outputs are sampled just after the edge, so the values seen are the
   // ones the block presented at that edge. Ready drops in random bursts under idle_on.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Presents one request and holds it until the block takes it. Valid is left high
   // afterwards so that back-to-back requests never see it drop and rise in one step.
   task automatic send_row(logic [30:0] row, logic [63:0] sec, logic [32:0] nraw,
                           logic nul, logic bend);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tdata  <= {nraw, sec, row};
      req_tuser  <= nul;
      req_tlast  <= bend;
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(row, sec, nraw, nul, bend);
   endtask

   // Stops sending and waits until every outstanding row has come back, then runs on
   // so that the pipeline is certainly empty before any register changes.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_rows.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register word for one index, with random junk above the register's width at times;
   // the block is expected to ignore those bits.
   function automatic logic [63:0] reg_word(cfg_type c, logic [2:0] idx);
      logic [63:0] w;
      logic [63:0] keep;
      case (idx)
         CSR_PRECISION: begin
            w = 64'(c.precision_mode);
            keep = 64'h3;
         end
         CSR_FILTER: begin
            w = 64'(c.filter_mode);
            keep = 64'h3;
         end
         CSR_NULL_PASS: begin
            w = 64'(c.range_null_pass);
            keep = 64'h1;
         end
         CSR_LOW_SECS: begin
            w = c.range_low_seconds;
            keep = '1;
         end
         CSR_LOW_NANOS: begin
            w = 64'(c.range_low_nanos);
            keep = 64'h3FFF_FFFF;
         end
         CSR_HIGH_SECS: begin
            w = c.range_high_seconds;
            keep = '1;
         end
         CSR_HIGH_NANOS: begin
            w = 64'(c.range_high_nanos);
            keep = 64'h3FFF_FFFF;
         end
         default: begin
            w = {{31{c.secs_offset[32]}}, c.secs_offset};
            keep = 64'h1_FFFF_FFFF;
         end
      endcase
      if ($urandom_range(0, 1))
         w = w | ({$urandom, $urandom} & ~keep);
      return w;
   endfunction

   // Writes all eight registers, one per cycle; only called while the block is empty.
   task automatic program_setting(cfg_type c);
      logic [2:0]  idx;
      logic [63:0] w;
      for (int i = 0; i < 8; i++) begin
         idx = 3'(i);
         w = reg_word(c, idx);
         csr_wen   <= 1'b1;
         csr_index <= idx;
         csr_wdata <= w;
         @(posedge clock);
         sb.write_reg(idx, w);
      end
      csr_wen <= 1'b0;
   endtask

   // A few fixed settings that reach the extremes, then random range settings around a
   // random centre so that rows near the bounds are common.
   function automatic cfg_type setting_for(int p);
      cfg_type     c;
      logic [63:0] centre;
      centre = $urandom_range(0, 1) ? {$urandom, $urandom}
                                    : 64'($urandom_range(0, 200)) - 64'd100;
      c.precision_mode     = 2'($urandom_range(0, 3));
      c.filter_mode        = FILT_RANGE;
      c.range_null_pass    = 1'($urandom_range(0, 1));
      c.range_low_seconds  = centre - 64'($urandom_range(0, 3));
      c.range_low_nanos    = 30'($urandom_range(0, NS_MAX));
      c.range_high_seconds = centre + 64'($urandom_range(0, 3));
      c.range_high_nanos   = 30'($urandom_range(0, NS_MAX));
      c.secs_offset        = 33'({$urandom, $urandom});
      case (p)
         1: begin
            c.precision_mode     = PREC_MS;
            c.range_null_pass    = 1'b1;
            c.range_low_seconds  = 64'd0 - 64'd5;
            c.range_low_nanos    = 30'd500000000;
            c.range_high_seconds = 64'd5;
            c.range_high_nanos   = NS_MAX;
            c.secs_offset        = 33'd0;
         end
         2: begin
            // Nanosecond bounds beyond the legal maximum and the most negative offset.
            c.precision_mode     = PREC_US;
            c.range_null_pass    = 1'b0;
            c.range_low_seconds  = 64'd0 - 64'd100;
            c.range_low_nanos    = 30'h3FFF_FFFF;
            c.range_high_seconds = 64'd100;
            c.range_high_nanos   = 30'h3FFF_FFFF;
            c.secs_offset        = 33'h1_0000_0000;
         end
         3: begin
            c.precision_mode = PREC_CODE3;
            c.filter_mode    = FILT_NULLS;
            c.secs_offset    = 33'h0_FFFF_FFFF;
         end
         4: begin
            c.precision_mode = PREC_NS;
            c.filter_mode    = FILT_NONNULL;
         end
         5: begin
            // Lower bound above the upper one: nothing but nulls can be selected.
            c.range_low_seconds  = 64'd10;
            c.range_low_nanos    = 30'd0;
            c.range_high_seconds = 64'd0 - 64'd10;
            c.range_high_nanos   = 30'd0;
         end
         6: begin
            c.range_null_pass    = 1'b1;
            c.range_low_seconds  = 64'h8000_0000_0000_0000;
            c.range_low_nanos    = 30'd0;
            c.range_high_seconds = 64'h7FFF_FFFF_FFFF_FFFF;
            c.range_high_nanos   = 30'h3FFF_FFFF;
            c.secs_offset        = 33'h1_0000_0000;
         end
         7: begin
            c.precision_mode = PREC_MS;
            c.filter_mode    = FILT_ALL;
         end
         default: ;
      endcase
      return c;
   endfunction

   // One random row. Most rows are aimed at interesting seconds: around the range bounds,
   // around a decoded value of zero (where the minus-one adjustment applies) and at the
   // 64-bit extremes. The rest is raw noise and ordinary well-formed rows.
   task automatic send_random_row();
      logic [63:0] off;
      logic [63:0] sec;
      logic [63:0] bound_s;
      logic [63:0] m;
      logic [32:0] nraw;
      logic        upper;
      off = {{31{sb.regs.secs_offset[32]}}, sb.regs.secs_offset};
      nraw = random_nanos();
      upper = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: begin
            sec  = {$urandom, $urandom};
            nraw = 33'({$urandom, $urandom});
         end
         1, 2, 3: begin
            bound_s = upper ? sb.regs.range_high_seconds : sb.regs.range_low_seconds;
            m = upper ? 64'(sb.regs.range_high_nanos) : 64'(sb.regs.range_low_nanos);
            if (m > 64'(NS_MAX))
               m = 64'(NS_MAX);
            sec = bound_s + 64'($urandom_range(0, 4)) - 64'd2 - off;
            if ($urandom_range(0, 2) != 0) begin
               if (m < 64'd2)
                  m = 64'd2;
               m = m + 64'($urandom_range(0, 4)) - 64'd2;
               if (m > 64'(NS_MAX))
                  m = 64'(NS_MAX);
               nraw = {m[29:0], 3'd0};
            end
         end
         4, 5: sec = 64'($urandom_range(0, 4)) - 64'd2 - off;
         6: begin
            sec = upper ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            if ($urandom_range(0, 1))
               sec = sec - off;
         end
         default: begin
            if ($urandom_range(0, 1))
               sec = {$urandom, $urandom};
            else
               sec = 64'($urandom_range(0, 2000000)) - 64'd1000000;
         end
      endcase
      send_row(31'($urandom), sec, nraw, $urandom_range(0, 3) == 0,
               $urandom_range(0, 7) == 0);
   endtask

   initial begin
      logic [63:0] off;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rows under the reset settings: full nanoseconds, pass all, default offset.
      off = {{31{sb.regs.secs_offset[32]}}, sb.regs.secs_offset};
      send_row(31'd0, 64'd0, 33'd0, 1'b0, 1'b0);
      // Largest seconds wrap past the top once the offset is added; all-ones nanos saturate.
      send_row(31'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 33'h1_FFFF_FFFF, 1'b0, 1'b1);
      send_row(31'h2AAA_AAAA, 64'h8000_0000_0000_0000, 33'd0, 1'b0, 1'b0);
      // A null row with busy fields must come back with zero time.
      send_row(31'h5555_5555, {$urandom, $urandom}, 33'h1_FFFF_FFFF, 1'b1, 1'b1);
      for (int z = 1; z < 8; z++)
         send_row(31'(z), 64'(1000 + z), {30'd1, 3'(z)}, 1'b0, 1'b0);
      send_row(31'd20, 64'd0 - off, {30'h3FFF_FFFF, 3'd0}, 1'b0, 1'b0);
      // Decoded seconds of minus one, with and without nanoseconds.
      send_row(31'd21, 64'd0 - off - 64'd1, {30'd5, 3'd0}, 1'b0, 1'b0);
      send_row(31'd22, 64'd0 - off - 64'd1, 33'd0, 1'b0, 1'b0);
      // Mantissa exactly at, and one above, the limit for a zero count of one.
      send_row(31'd23, 64'd0 - off, {30'd9999999, 3'd1}, 1'b0, 1'b0);
      send_row(31'd24, 64'd0 - off - 64'd1, {30'd10000000, 3'd1}, 1'b0, 1'b0);
      send_row(31'd25, 64'hFFFF_FFFF_FFFF_FFFF, {30'd999999999, 3'd0}, 1'b0, 1'b1);
      // Zero mantissa with a nonzero count still decodes to zero nanoseconds.
      send_row(31'd26, 64'd0 - off - 64'd3, {30'd0, 3'd4}, 1'b0, 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            wait_drained();
            program_setting(setting_for(p));
            idle_on <= (p % 3 != 2) && (p != NUM_PHASES - 1);
         end
         for (int i = 0; i < ROWS_PER_PHASE; i++) begin
            // Now and then the sender holds back until the block has emptied completely.
            if (p % 2 == 1 && i == ROWS_PER_PHASE / 2)
               wait_drained();
            send_random_row();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending_rows.size() == 0)
         $display("orc_timestamp_decode_filter_tb OK");
      else
         $display("orc_timestamp_decode_filter_tb NOT OK");
      $finish;
   end

   // Guard against a block that stops responding.
   initial begin
      #3000000;
      $display("orc_timestamp_decode_filter_tb NOT OK");
      $finish;
   end

endmodule
